// ----- hw/rtl/allocation_tracker_table_macros.svh -----
// Assertion helpers used by allocation_tracker_table.sv.
`ifndef ALLOCATION_TRACKER_TABLE_MACROS_SVH
`define ALLOCATION_TRACKER_TABLE_MACROS_SVH

// Checked only outside reset.
`define ATB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ATB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/atb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package atb_pkg;

  localparam int CAPACITY            = 1024;
  localparam int BASE_OVERHEAD_BYTES = 524288;
  localparam int ENTRY_BYTES         = 40;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int NSTAT  = 19;
  localparam int STAT_W = $clog2(NSTAT);

  localparam logic [63:0] U64_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BASE_OVH  = 64'(BASE_OVERHEAD_BYTES);
  localparam logic [63:0] OBS_LIMIT = (U64_MAX - BASE_OVH) / 64'(ENTRY_BYTES);

  // commands
  localparam logic [2:0] CMD_BEGIN = 3'd0;
  localparam logic [2:0] CMD_ALLOC = 3'd1;
  localparam logic [2:0] CMD_FREE  = 3'd2;
  localparam logic [2:0] CMD_ARENA = 3'd3;
  localparam logic [2:0] CMD_RC    = 3'd4;
  localparam logic [2:0] CMD_SNAP  = 3'd5;
  localparam logic [2:0] CMD_END   = 3'd6;

  // refcount ops
  localparam logic [2:0] RC_RETAIN_CALL  = 3'd0;
  localparam logic [2:0] RC_RELEASE_CALL = 3'd1;
  localparam logic [2:0] RC_RETAIN_OP    = 3'd2;
  localparam logic [2:0] RC_RELEASE_OP   = 3'd3;

  // statistic slots
  localparam logic [STAT_W-1:0] S_ALLOCS          = STAT_W'(0);
  localparam logic [STAT_W-1:0] S_HEAP_ALLOCS     = STAT_W'(1);
  localparam logic [STAT_W-1:0] S_ARENA_ALLOCS    = STAT_W'(2);
  localparam logic [STAT_W-1:0] S_HEAP_FREES      = STAT_W'(3);
  localparam logic [STAT_W-1:0] S_ARENA_RECLAIMS  = STAT_W'(4);
  localparam logic [STAT_W-1:0] S_UNKNOWN_FREES   = STAT_W'(5);
  localparam logic [STAT_W-1:0] S_TOTAL_DATA      = STAT_W'(6);
  localparam logic [STAT_W-1:0] S_TOTAL_HEADER    = STAT_W'(7);
  localparam logic [STAT_W-1:0] S_LIVE_ALLOCS     = STAT_W'(8);
  localparam logic [STAT_W-1:0] S_LIVE_DATA       = STAT_W'(9);
  localparam logic [STAT_W-1:0] S_LIVE_HEADER     = STAT_W'(10);
  localparam logic [STAT_W-1:0] S_PEAK_LIVE_ALLOCS = STAT_W'(11);
  localparam logic [STAT_W-1:0] S_PEAK_LIVE_DATA  = STAT_W'(12);
  localparam logic [STAT_W-1:0] S_PEAK_OBSERVER   = STAT_W'(13);
  localparam logic [STAT_W-1:0] S_RETAIN_CALLS    = STAT_W'(14);
  localparam logic [STAT_W-1:0] S_RELEASE_CALLS   = STAT_W'(15);
  localparam logic [STAT_W-1:0] S_RETAIN_OPS      = STAT_W'(16);
  localparam logic [STAT_W-1:0] S_RELEASE_OPS     = STAT_W'(17);
  localparam logic [STAT_W-1:0] S_ERRORS          = STAT_W'(18);

  typedef struct packed {
    logic        used;
    logic [47:0] addr;
    logic [47:0] arena;
    logic [47:0] data;
    logic [47:0] hdr;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic put;
    logic drop;
  } ring_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/atb_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module atb_cell (
  input  wire              clk,
  input  wire              rst,
  input  wire              shift,
  input  wire              clear,
  input  atb_pkg::entry_t  din,
  output atb_pkg::entry_t  q
);
  import atb_pkg::*;

  logic        used;
  logic [47:0] addr;
  logic [47:0] arena;
  logic [47:0] data;
  logic [47:0] hdr;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      used <= 1'b0;
    end else if (shift) begin
      used <= din.used;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      addr  <= din.addr;
      arena <= din.arena;
      data  <= din.data;
      hdr   <= din.hdr;
    end
  end

  assign q = {used, addr, arena, data, hdr};

endmodule
`default_nettype wire

// ----- hw/rtl/atb_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none
module atb_ring (
  input  wire                clk,
  input  wire                rst,
  input  atb_pkg::ring_ctl_t ctl,
  input  atb_pkg::entry_t    put_entry,
  output atb_pkg::entry_t    head
);
  import atb_pkg::*;

  entry_t q [CAPACITY];
  entry_t head_mod;

  // the head cell is the only one the controller sees; whatever it leaves
  // there wraps to the tail on a shift
  always_comb begin
    head_mod = q[0];
    if (ctl.put) begin
      head_mod = put_entry;
    end else if (ctl.drop) begin
      head_mod.used = 1'b0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t din;
    if (i == CAPACITY - 1) begin : g_tail
      assign din = head_mod;
    end else begin : g_mid
      assign din = q[i+1];
    end
    atb_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.shift),
      .clear (ctl.clear),
      .din   (din),
      .q     (q[i])
    );
  end

  assign head = q[0];

endmodule
`default_nettype wire

// ----- hw/rtl/allocation_tracker_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  tdata                                         tuser     tlast
// s_axis    in   address, total_size, header_size, arena_id,   cmd       -
//                rc_op
// m_axis    out  ok, counter_id, counter_value                 kind      last
//
// One command at a time. Begin, refcount, snapshot, end and unused codes are
// answered in the cycle after acceptance; snapshot/end stream 20 transactions.
// Free and arena reset rotate the entry ring, one cell a cycle, up to CAPACITY
// cells. Alloc scans CAPACITY cells, rotates up to CAPACITY more to reach a
// free cell, then updates peaks in ST_PEAK and ST_OBS. No clearing pass after
// reset. A stalled output holds the block; no input is taken until it drains.
`include "allocation_tracker_table_macros.svh"
module allocation_tracker_table (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // [47:0] address, [95:48] total_size, [143:96] header_size,
  // [191:144] arena_id, [194:192] rc_op
  input  wire  [199:0] s_axis_tdata,
  // [2:0] cmd
  input  wire  [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // [0] ok, [5:1] counter_id, [69:6] counter_value
  output logic [71:0]  m_axis_tdata,
  // [0] kind
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import atb_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_PLACE = 3'd2;
  localparam logic [2:0] ST_PEAK  = 3'd3;
  localparam logic [2:0] ST_OBS   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [4:0] LAST_ID = 5'(NSTAT);

  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {1'b1, U64_MAX} : s;
  endfunction

  function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    return (a < b) ? {1'b1, 64'd0} : {1'b0, a - b};
  endfunction

  logic [2:0]       state, state_next;
  logic             active, active_next;
  logic             valid, valid_next;
  logic [63:0]      stat [NSTAT];
  logic [63:0]      stat_next [NSTAT];
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] scnt, scnt_next;
  logic             dup, dup_next;
  logic [2:0]       op_cmd;
  logic [47:0]      op_addr, op_total, op_hdr, op_arena;
  logic [63:0]      obs_prod;
  logic             obs_ovf;

  logic             out_valid, out_valid_next;
  logic             out_kind, out_kind_next;
  logic             out_ok, out_ok_next;
  logic [4:0]       out_id, out_id_next;
  logic [63:0]      out_value, out_value_next;
  logic             out_last, out_last_next;

  ring_ctl_t        ctl;
  entry_t           head, put_entry;

  logic             in_fire, out_fire;
  logic [2:0]       in_cmd, in_rc;
  logic [47:0]      in_addr, in_total, in_hdr, in_arena;

  assign in_cmd   = s_axis_tuser;
  assign in_addr  = s_axis_tdata[47:0];
  assign in_total = s_axis_tdata[95:48];
  assign in_hdr   = s_axis_tdata[143:96];
  assign in_arena = s_axis_tdata[191:144];
  assign in_rc    = s_axis_tdata[194:192];

  assign s_axis_tready = (state == ST_IDLE) && !out_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid && m_axis_tready;

  assign put_entry = {1'b1, op_addr, op_arena, op_total - op_hdr, op_hdr};

  atb_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .put_entry (put_entry),
    .head      (head)
  );

  always_comb begin
    logic [64:0]       r;
    logic [3:0]        nerr;
    logic              go_ack, go_read, match_addr, match_arena, scan_end;
    logic [STAT_W-1:0] sel;
    logic [63:0]       ovh;

    state_next     = state;
    active_next    = active;
    valid_next     = valid;
    count_next     = count;
    scnt_next      = scnt;
    dup_next       = dup;
    stat_next      = stat;
    out_valid_next = out_valid;
    out_kind_next  = out_kind;
    out_ok_next    = out_ok;
    out_id_next    = out_id;
    out_value_next = out_value;
    out_last_next  = out_last;
    ctl            = '0;
    nerr           = 4'd0;
    go_ack         = 1'b0;
    go_read        = 1'b0;
    r              = '0;
    sel            = S_HEAP_FREES;
    ovh            = '0;
    match_addr     = head.used && (head.addr == op_addr);
    match_arena    = head.used && (head.arena == op_arena);
    scan_end       = (scnt == CNT_W'(CAPACITY - 1));

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          scnt_next = '0;
          dup_next  = 1'b0;
          unique case (in_cmd)
            CMD_BEGIN: begin
              go_ack = 1'b1;
              if (active) begin
                nerr = 4'd1;
              end else begin
                for (int k = 0; k < NSTAT; k++) stat_next[k] = '0;
                stat_next[S_PEAK_OBSERVER] = BASE_OVH;
                valid_next  = 1'b1;
                active_next = 1'b1;
                ctl.clear   = 1'b1;
                count_next  = '0;
                out_ok_next = 1'b1;
              end
            end
            CMD_ALLOC: begin
              if (!active) begin
                go_ack = 1'b1;
              end else if (in_addr == '0 || in_total < in_hdr ||
                           count == CNT_W'(CAPACITY)) begin
                nerr   = 4'd1;
                go_ack = 1'b1;
              end else begin
                state_next = ST_SCAN;
              end
            end
            CMD_FREE: begin
              if (active && in_addr != '0) state_next = ST_SCAN;
              else go_ack = 1'b1;
            end
            CMD_ARENA: begin
              if (active && in_arena != '0) state_next = ST_SCAN;
              else go_ack = 1'b1;
            end
            CMD_RC: begin
              go_ack = 1'b1;
              if (active) begin
                unique case (in_rc)
                  RC_RETAIN_CALL:  sel = S_RETAIN_CALLS;
                  RC_RELEASE_CALL: sel = S_RELEASE_CALLS;
                  RC_RETAIN_OP:    sel = S_RETAIN_OPS;
                  RC_RELEASE_OP:   sel = S_RELEASE_OPS;
                  default:         nerr = 4'd1;
                endcase
                if (nerr == 4'd0) begin
                  r = sat_add(stat[sel], 64'd1);
                  stat_next[sel] = r[63:0];
                  nerr = {3'd0, r[64]};
                end
              end
            end
            CMD_SNAP: go_read = 1'b1;
            CMD_END: begin
              go_read     = 1'b1;
              active_next = 1'b0;
              ctl.clear   = 1'b1;
              count_next  = '0;
            end
            default: go_ack = 1'b1;
          endcase
        end
      end

      ST_SCAN: begin
        ctl.shift = 1'b1;
        scnt_next = scnt + CNT_W'(1);
        if (op_cmd == CMD_ALLOC) begin
          if (match_addr) dup_next = 1'b1;
          if (scan_end) begin
            if (dup || match_addr) begin
              nerr   = 4'd1;
              go_ack = 1'b1;
            end else begin
              state_next = ST_PLACE;
            end
          end
        end else if ((op_cmd == CMD_FREE && match_addr) ||
                     (op_cmd == CMD_ARENA && match_arena)) begin
          ctl.drop   = 1'b1;
          count_next = count - CNT_W'(1);
          sel = (head.arena != '0) ? S_ARENA_RECLAIMS : S_HEAP_FREES;
          r = sat_add(stat[sel], 64'd1);
          stat_next[sel] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
          r = sat_sub(stat[S_LIVE_ALLOCS], 64'd1);
          stat_next[S_LIVE_ALLOCS] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
          r = sat_sub(stat[S_LIVE_DATA], {16'd0, head.data});
          stat_next[S_LIVE_DATA] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
          r = sat_sub(stat[S_LIVE_HEADER], {16'd0, head.hdr});
          stat_next[S_LIVE_HEADER] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
          if (op_cmd == CMD_FREE || scan_end) go_ack = 1'b1;
        end else if (scan_end) begin
          go_ack = 1'b1;
          if (op_cmd == CMD_FREE) begin
            r = sat_add(stat[S_UNKNOWN_FREES], 64'd1);
            stat_next[S_UNKNOWN_FREES] = r[63:0];
            nerr = {3'd0, r[64]} + 4'd1;
          end
        end
      end

      ST_PLACE: begin
        ctl.shift = 1'b1;
        if (!head.used) begin
          ctl.put    = 1'b1;
          count_next = count + CNT_W'(1);
          state_next = ST_PEAK;
          r = sat_add(stat[S_ALLOCS], 64'd1);
          stat_next[S_ALLOCS] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
          sel = (op_arena != '0) ? S_ARENA_ALLOCS : S_HEAP_ALLOCS;
          r = sat_add(stat[sel], 64'd1);
          stat_next[sel] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
          r = sat_add(stat[S_TOTAL_DATA], {16'd0, put_entry.data});
          stat_next[S_TOTAL_DATA] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
          r = sat_add(stat[S_TOTAL_HEADER], {16'd0, op_hdr});
          stat_next[S_TOTAL_HEADER] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
          r = sat_add(stat[S_LIVE_ALLOCS], 64'd1);
          stat_next[S_LIVE_ALLOCS] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
          r = sat_add(stat[S_LIVE_DATA], {16'd0, put_entry.data});
          stat_next[S_LIVE_DATA] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
          r = sat_add(stat[S_LIVE_HEADER], {16'd0, op_hdr});
          stat_next[S_LIVE_HEADER] = r[63:0];
          nerr = nerr + {3'd0, r[64]};
        end
      end

      ST_PEAK: begin
        if (stat[S_LIVE_ALLOCS] > stat[S_PEAK_LIVE_ALLOCS])
          stat_next[S_PEAK_LIVE_ALLOCS] = stat[S_LIVE_ALLOCS];
        if (stat[S_LIVE_DATA] > stat[S_PEAK_LIVE_DATA])
          stat_next[S_PEAK_LIVE_DATA] = stat[S_LIVE_DATA];
        state_next = ST_OBS;
      end

      ST_OBS: begin
        go_ack = 1'b1;
        if (obs_ovf) begin
          nerr = 4'd1;
        end else begin
          ovh = BASE_OVH + obs_prod;
          if (ovh > stat[S_PEAK_OBSERVER]) stat_next[S_PEAK_OBSERVER] = ovh;
        end
      end

      ST_OUT: begin
        if (out_fire) begin
          if (out_last) begin
            out_valid_next = 1'b0;
            state_next     = ST_IDLE;
          end else begin
            out_id_next    = out_id + 5'd1;
            out_value_next = stat[STAT_W'(out_id)];
            out_last_next  = (out_id + 5'd1 == LAST_ID);
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase

    // each clamp or bad command counts once
    if (nerr != 4'd0) begin
      valid_next = 1'b0;
      r = sat_add(stat_next[S_ERRORS], {60'd0, nerr});
      stat_next[S_ERRORS] = r[63:0];
    end

    if (go_ack) begin
      state_next     = ST_OUT;
      out_valid_next = 1'b1;
      out_kind_next  = 1'b0;
      out_ok_next    = (state == ST_IDLE) && (in_cmd == CMD_BEGIN) && !active;
      out_id_next    = '0;
      out_value_next = '0;
      out_last_next  = 1'b1;
    end
    if (go_read) begin
      state_next     = ST_OUT;
      out_valid_next = 1'b1;
      out_kind_next  = 1'b1;
      out_ok_next    = 1'b0;
      out_id_next    = '0;
      out_value_next = {63'd0, valid};
      out_last_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= 1'b0;
      valid     <= 1'b0;
      count     <= '0;
      scnt      <= '0;
      dup       <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < NSTAT; k++) stat[k] <= '0;
    end else begin
      state     <= state_next;
      active    <= active_next;
      valid     <= valid_next;
      count     <= count_next;
      scnt      <= scnt_next;
      dup       <= dup_next;
      out_valid <= out_valid_next;
      stat      <= stat_next;
    end
  end

  always_ff @(posedge clk) begin
    out_kind  <= out_kind_next;
    out_ok    <= out_ok_next;
    out_id    <= out_id_next;
    out_value <= out_value_next;
    out_last  <= out_last_next;
    if (in_fire) begin
      op_cmd   <= in_cmd;
      op_addr  <= in_addr;
      op_total <= in_total;
      op_hdr   <= in_hdr;
      op_arena <= in_arena;
    end
    obs_prod <= stat[S_LIVE_ALLOCS] * 64'(ENTRY_BYTES);
    obs_ovf  <= stat[S_LIVE_ALLOCS] > OBS_LIMIT;
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = {2'b00, out_value, out_id, out_ok};
  assign m_axis_tuser[0] = out_kind;
  assign m_axis_tlast    = out_last;

  `ATB_ASSERT(a_fill_bound, count <= CNT_W'(CAPACITY), "fill count above capacity")
  `ATB_ASSERT_ALWAYS(a_no_take_while_out, s_axis_tready |-> !m_axis_tvalid,
    "input taken while a result is pending")
  `ATB_ASSERT(a_put_free, ctl.put |-> !head.used, "insert over a live entry")
  `ATB_ASSERT(a_run_end, (m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast) |->
    (m_axis_tdata[5:1] == LAST_ID), "readout ends at the wrong counter")

endmodule
`default_nettype wire
